// ===== rtl/record_slot_bitmap_allocator_top_defines.svh =====
// Assertion macros for the record slot bitmap allocator.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef RECORD_SLOT_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define RECORD_SLOT_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define RSBA_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rsba: check failed");

// Next-cycle implication, disabled while in reset
`define RSBA_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rsba: check failed");

`endif

// ===== rtl/rsba_pkg.sv =====
// Shared types, codes and defaults for the record slot bitmap allocator.
// No dependencies; used by every module of the block.
`default_nettype none

package rsba_pkg;

  // Default configuration
  localparam int SLOTS_DEF        = 2016;
  localparam int RECORD_BYTES_DEF = 8;
  localparam int PAGE_BYTES_DEF   = 64;
  localparam int BASE_PAGE_DEF    = 4;

  // Fixed field widths
  localparam int OP_W      = 3;
  localparam int IDX_W     = 11;
  localparam int ADDR_W    = 14;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 12;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;

  localparam logic [CNT_W-1:0] CNT_OUT_MAX = CNT_W'(2047);

  // Operation codes
  localparam logic [OP_W-1:0] OP_FIND_FREE = 3'd0;
  localparam logic [OP_W-1:0] OP_FIND_USED = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK_USED = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MARK
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] slot_index;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    found_index;
    logic [ADDR_W-1:0]   slot_address;
    logic [IDX_W-1:0]    used_count;
  } result_t;

  // Bitmap memory control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } mem_ctl_t;

  // Word search outcome
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] bit_pos;
  } scan_hit_t;

endpackage

`default_nettype wire

// ===== rtl/rsba_map_mem.sv =====
// Occupancy bitmap memory: one 32-bit word per row, registered read, per-row valid bits.
// Depends on rsba_pkg for the word width and control struct.
`default_nettype none

module rsba_map_mem #(
  parameter int DEPTH  = 63,
  parameter int AW     = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rsba_pkg::mem_ctl_t          ctl,
  input  wire logic [AW-1:0]               rd_addr,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [rsba_pkg::WORD_BITS-1:0] wr_data,
  output logic [rsba_pkg::WORD_BITS-1:0]   rd_word
);

  logic [rsba_pkg::WORD_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]               row_valid;
  logic [rsba_pkg::WORD_BITS-1:0] rd_data;
  logic                           rd_valid;

  // Write the row array
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track which rows hold written data; clear all drops them at once
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      row_valid <= '0;
    end else if (ctl.wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // Register the read data and its valid bit
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= row_valid[rd_addr];
    end
  end

  // Unwritten rows read as all free
  assign rd_word = rd_valid ? rd_data : '0;

endmodule

`default_nettype wire

// ===== rtl/rsba_word_scan.sv =====
// Searches one bitmap word for the lowest free slot or the highest used slot.
// Depends on rsba_pkg; masks slots past the end in the last word.
`default_nettype none

module rsba_word_scan #(
  parameter int SLOTS = rsba_pkg::SLOTS_DEF
) (
  input  wire logic [rsba_pkg::WORD_BITS-1:0] word,
  input  wire logic                           find_free,
  input  wire logic                           last_word,
  output rsba_pkg::scan_hit_t                 hit
);

  localparam int MAP_WORDS = (SLOTS + 31) / 32;
  localparam int TAIL_BITS = SLOTS - (MAP_WORDS - 1) * 32;
  localparam logic [rsba_pkg::WORD_BITS-1:0] TAIL_MASK =
    rsba_pkg::WORD_BITS'((64'd1 << TAIL_BITS) - 64'd1);

  logic [rsba_pkg::WORD_BITS-1:0] cand;

  // Pick candidate bits: free slots inside range, or used slots
  always_comb begin
    if (find_free) begin
      cand = ~word & (last_word ? TAIL_MASK : '1);
    end else begin
      cand = word;
    end
  end

  // Priority encode: lowest for free, highest for used
  always_comb begin
    hit.hit     = |cand;
    hit.bit_pos = '0;
    if (find_free) begin
      for (int i = rsba_pkg::WORD_BITS - 1; i >= 0; i--) begin
        if (cand[i]) hit.bit_pos = rsba_pkg::BIT_W'(i);
      end
    end else begin
      for (int i = 0; i < rsba_pkg::WORD_BITS; i++) begin
        if (cand[i]) hit.bit_pos = rsba_pkg::BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/record_slot_bitmap_allocator_top.sv =====
// Top level of the record slot bitmap allocator: sequencer, slot count and result register.
// Depends on rsba_pkg, rsba_map_mem, rsba_word_scan and the assertion macro header.
//
// Usage:
//   A command (opcode, slot_index) is taken at a rising edge with start high and
//   busy low. Exactly one result follows per command; done is high for one cycle
//   with status, found_index, slot_address and used_count on result. The receiver
//   cannot hold results off, so each result is valid only during its done cycle.
// Sequencing:
//   Find free / find used scan the bitmap one word per cycle from the memory's
//   registered read port, busy while words are scanned, at most ceil(SLOTS/32)
//   words (63 at the default size). Mark used / mark free do one read-modify-write
//   of a bitmap word. Clear all, out-of-range marks and unused opcodes keep busy
//   low. done is high in the cycle right after the last busy cycle (the cycle
//   after acceptance when busy stays low), and a new command may be accepted at
//   the edge that ends that cycle.
// Reset:
//   Synchronous reset empties the bitmap at once through per-row valid bits,
//   zeroes the count and returns the sequencer to idle; no clearing pass is needed.
`default_nettype none

`include "record_slot_bitmap_allocator_top_defines.svh"

module record_slot_bitmap_allocator_top #(
  parameter int SLOTS        = rsba_pkg::SLOTS_DEF,
  parameter int RECORD_BYTES = rsba_pkg::RECORD_BYTES_DEF,
  parameter int PAGE_BYTES   = rsba_pkg::PAGE_BYTES_DEF,
  parameter int BASE_PAGE    = rsba_pkg::BASE_PAGE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire rsba_pkg::cmd_t    cmd,
  output logic                   busy,
  output logic                   done,
  output rsba_pkg::result_t      result
);

  localparam int MAP_WORDS = (SLOTS + 31) / 32;
  localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);
  localparam logic [rsba_pkg::CNT_W-1:0] SLOTS_CNT = rsba_pkg::CNT_W'(SLOTS);
  localparam logic [rsba_pkg::ADDR_W-1:0] ADDR_BASE =
    rsba_pkg::ADDR_W'(BASE_PAGE * PAGE_BYTES);

  // Registers
  rsba_pkg::state_t               state, state_next;
  logic [WORD_W-1:0]              cur, cur_next;
  logic                           scan_free, scan_free_next;
  logic                           mark_used, mark_used_next;
  logic [rsba_pkg::IDX_W-1:0]     idx_q, idx_next;
  logic [rsba_pkg::CNT_W-1:0]     cnt, cnt_next;
  logic                           done_next;
  rsba_pkg::result_t              result_next;

  // Datapath
  rsba_pkg::mem_ctl_t             mem_ctl;
  logic [WORD_W-1:0]              rd_addr;
  logic [WORD_W-1:0]              wr_addr;
  logic [rsba_pkg::WORD_BITS-1:0] wr_data;
  logic [rsba_pkg::WORD_BITS-1:0] rd_word;
  rsba_pkg::scan_hit_t            hit;
  logic                           accept;
  logic                           in_range;
  logic                           at_end;
  logic [WORD_W-1:0]              cur_step;
  logic                           bit_was;
  logic [rsba_pkg::WORD_BITS-1:0] bit_mask;
  logic [rsba_pkg::STATUS_W-1:0]  res_status;
  logic [rsba_pkg::IDX_W-1:0]     res_idx;
  logic                           res_has_addr;

  assign busy     = (state != rsba_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign in_range = {1'b0, cmd.slot_index} < SLOTS_CNT;
  assign at_end   = scan_free ? (cur == LAST_WORD) : (cur == '0);
  assign cur_step = scan_free ? cur + WORD_W'(1) : cur - WORD_W'(1);
  assign bit_mask = rsba_pkg::WORD_BITS'(1) << idx_q[rsba_pkg::BIT_W-1:0];
  assign bit_was  = |(rd_word & bit_mask);
  assign wr_addr  = idx_q[WORD_W+rsba_pkg::BIT_W-1:rsba_pkg::BIT_W];
  assign wr_data  = mark_used ? (rd_word | bit_mask) : (rd_word & ~bit_mask);

  rsba_map_mem #(
    .DEPTH (MAP_WORDS),
    .AW    (WORD_W)
  ) u_map_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_word (rd_word)
  );

  rsba_word_scan #(
    .SLOTS (SLOTS)
  ) u_word_scan (
    .word      (rd_word),
    .find_free (scan_free),
    .last_word (cur == LAST_WORD),
    .hit       (hit)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rsba_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd.opcode == rsba_pkg::OP_FIND_FREE ||
              cmd.opcode == rsba_pkg::OP_FIND_USED) begin
            state_next = rsba_pkg::S_SCAN;
          end else if ((cmd.opcode == rsba_pkg::OP_MARK_USED ||
                        cmd.opcode == rsba_pkg::OP_MARK_FREE) && in_range) begin
            state_next = rsba_pkg::S_MARK;
          end
        end
      end
      rsba_pkg::S_SCAN: begin
        if (hit.hit || at_end) state_next = rsba_pkg::S_IDLE;
      end
      rsba_pkg::S_MARK: begin
        state_next = rsba_pkg::S_IDLE;
      end
      default: begin
        state_next = rsba_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs and datapath next values
  always_comb begin
    mem_ctl        = '0;
    rd_addr        = cur;
    cur_next       = cur;
    scan_free_next = scan_free;
    mark_used_next = mark_used;
    idx_next       = idx_q;
    cnt_next       = cnt;
    done_next      = 1'b0;
    res_status     = rsba_pkg::ST_OK;
    res_idx        = '0;
    res_has_addr   = 1'b0;
    case (state)
      rsba_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd.opcode)
            rsba_pkg::OP_FIND_FREE: begin
              mem_ctl.rd_en  = 1'b1;
              rd_addr        = '0;
              cur_next       = '0;
              scan_free_next = 1'b1;
            end
            rsba_pkg::OP_FIND_USED: begin
              mem_ctl.rd_en  = 1'b1;
              rd_addr        = LAST_WORD;
              cur_next       = LAST_WORD;
              scan_free_next = 1'b0;
            end
            rsba_pkg::OP_MARK_USED, rsba_pkg::OP_MARK_FREE: begin
              if (in_range) begin
                mem_ctl.rd_en  = 1'b1;
                rd_addr        = cmd.slot_index[WORD_W+rsba_pkg::BIT_W-1:rsba_pkg::BIT_W];
                mark_used_next = (cmd.opcode == rsba_pkg::OP_MARK_USED);
                idx_next       = cmd.slot_index;
              end else begin
                done_next  = 1'b1;
                res_status = rsba_pkg::ST_RANGE;
              end
            end
            rsba_pkg::OP_CLEAR_ALL: begin
              mem_ctl.clear = 1'b1;
              cnt_next      = '0;
              done_next     = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      rsba_pkg::S_SCAN: begin
        if (hit.hit) begin
          done_next    = 1'b1;
          res_idx      = rsba_pkg::IDX_W'({cur, hit.bit_pos});
          res_has_addr = 1'b1;
        end else if (at_end) begin
          done_next  = 1'b1;
          res_status = rsba_pkg::ST_NONE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = cur_step;
          cur_next      = cur_step;
        end
      end
      rsba_pkg::S_MARK: begin
        mem_ctl.wr_en = 1'b1;
        if (mark_used && !bit_was) begin
          cnt_next = cnt + rsba_pkg::CNT_W'(1);
        end else if (!mark_used && bit_was && cnt != '0) begin
          cnt_next = cnt - rsba_pkg::CNT_W'(1);
        end
        done_next    = 1'b1;
        res_idx      = idx_q;
        res_has_addr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Assemble the result word
  always_comb begin
    result_next.status      = res_status;
    result_next.found_index = res_idx;
    result_next.slot_address = res_has_addr ?
      ADDR_BASE + rsba_pkg::ADDR_W'(res_idx * RECORD_BYTES) : '0;
    result_next.used_count  = (cnt_next > rsba_pkg::CNT_OUT_MAX) ?
      '1 : cnt_next[rsba_pkg::IDX_W-1:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsba_pkg::S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  // Operation and result holding registers
  always_ff @(posedge clk) begin
    cur       <= cur_next;
    scan_free <= scan_free_next;
    mark_used <= mark_used_next;
    idx_q     <= idx_next;
    if (done_next) begin
      result <= result_next;
    end
  end

  // Checks
  `RSBA_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= SLOTS_CNT)
  `RSBA_ASSERT_IMP(a_wr_only_mark, clk, rst, mem_ctl.wr_en, state == rsba_pkg::S_MARK)
  `RSBA_ASSERT_IMP(a_fail_no_addr, clk, rst, done && result.status != rsba_pkg::ST_OK,
                   result.found_index == '0 && result.slot_address == '0)
  `RSBA_ASSERT_NXT(a_mark_enters, clk, rst,
                   accept && in_range && (cmd.opcode == rsba_pkg::OP_MARK_USED ||
                   cmd.opcode == rsba_pkg::OP_MARK_FREE),
                   state == rsba_pkg::S_MARK && !done)

endmodule

`default_nettype wire
